>>> rtl/mmrp_pkg.sv
// Shared types for the MIDI merge and remap parser: item structs for both
// channels, configuration, per-port parse context and queued message format.
// No dependencies.
package mmrp_pkg;

	// Default number of source ports.
	localparam int NUM_PORTS_DEF = 5;

	// Register widths.
	localparam int CHMAP_W = 25;
	localparam int TRMAP_W = 30;

	// APB port widths.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// One input transfer.
	typedef struct packed {
		logic [2:0] src_port;
		logic [7:0] in_byte;
		logic       rx_error;
	} src_item_t;

	// One output transfer.
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] out_port;
		logic       last;
	} msg_item_t;

	// Configuration register contents.
	typedef struct packed {
		logic [CHMAP_W-1:0] channel_map;
		logic [TRMAP_W-1:0] transpose_map;
	} cfg_t;

	// Per-port parse context; len2 set means a two-byte message.
	typedef struct packed {
		logic [1:0] pos;
		logic       len2;
		logic [7:0] run_status;
	} ctx_t;

	// Partial message bytes of one port.
	typedef logic [2:0][7:0] row_t;

	// A completed message waiting for the output channel.
	typedef struct packed {
		row_t       bytes;
		logic       len2;
		logic [2:0] port;
	} msg_t;

endpackage

>>> rtl/midi_merge_remap_parser_unit.sv
// MIDI merge and remap parser.
// Bytes enter on the src channel tagged with their source port. Error bytes,
// real-time bytes and bytes from ports at or above NUM_PORTS are taken and
// dropped. Each port keeps its own parse context in the state memory: a byte
// is read from memory in the cycle after its transfer, updated and written
// back when it leaves stage one, with a bypass so the next byte of the same
// port sees the update. The src channel takes one byte per cycle unless stage
// one is stalled. A completed message (two or three bytes) goes into a
// two-entry message queue and leaves on the msg channel one byte per
// transfer, status byte first, with last set on its final byte. The first
// byte of a message can be transferred once the completing byte has passed
// stage one and been pushed into the queue. Sustained throughput is bound by
// the msg channel at one byte per cycle.
// When the receiver stalls, the queue fills and the pipeline stage holds its
// byte, so src_ready drops until room frees up; nothing is lost.
// At reset every port starts at a message boundary with length three and
// running status 0x00, the channel map reads 470506 and the transpose map 0.
// Configuration must be written through the APB port only while the block is idle; this is not enforced.
// Depends on mmrp_pkg, mmrp_apb_regs, mmrp_state_ram and mmrp_out_queue.
module midi_merge_remap_parser_unit import mmrp_pkg::*; #(
	parameter int NUM_PORTS = NUM_PORTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  src_item_t          src_item,
	output logic               msg_valid,
	input  logic               msg_ready,
	output msg_item_t          msg_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int MAP_PORTS = 5;

	// Status nibbles and the real-time byte pattern.
	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_PROG     = 4'hC;
	localparam logic [3:0] ST_CHPRESS  = 4'hD;
	localparam logic [7:0] RT_MASK     = 8'hF8;

	// Channel map field of one port; ports without a field read zero.
	function automatic logic [4:0] chf_of(logic [CHMAP_W-1:0] map, logic [2:0] port);
		logic [4:0] res;
		res = 5'd0;
		for (int p = 0; p < MAP_PORTS; p++) begin
			if (port == 3'(p)) begin
				res = map[p*5 +: 5];
			end
		end
		return res;
	endfunction

	// Transpose field of one port; ports without a field read zero.
	function automatic logic [5:0] trf_of(logic [TRMAP_W-1:0] map, logic [2:0] port);
		logic [5:0] res;
		res = 6'd0;
		for (int p = 0; p < MAP_PORTS; p++) begin
			if (port == 3'(p)) begin
				res = map[p*6 +: 6];
			end
		end
		return res;
	endfunction

	cfg_t cfg;

	logic drop;
	logic take;
	logic v1_s1;
	logic [2:0] port_s1;
	logic [7:0] byte_s1;

	ctx_t rd_ctx;
	row_t rd_row;
	ctx_t nxt_ctx;
	row_t nxt_row;
	logic emit;
	logic fire1;
	logic q_full;
	logic push;
	msg_t push_msg;

	logic [4:0] chf;
	logic [5:0] tf;
	logic [7:0] b;
	logic [1:0] pos;
	logic       len2;
	logic [7:0] rs;
	logic [1:0] tr_pos;
	logic [8:0] sum;

	mmrp_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input filter: dropped bytes are taken but never reach the state memory.
	assign drop = (32'(src_item.src_port) >= NUM_PORTS) || src_item.rx_error ||
		((src_item.in_byte & RT_MASK) == RT_MASK);
	assign src_ready = !v1_s1 || fire1;
	assign take = src_valid && src_ready && !drop;

	// Stage one holds the byte whose context is being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (src_ready) begin
			v1_s1 <= src_valid && !drop;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			port_s1 <= src_item.src_port;
			byte_s1 <= src_item.in_byte;
		end
	end

	mmrp_state_ram #(.NUM_PORTS(NUM_PORTS)) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_addr (AW'(src_item.src_port)),
		.rd_ctx  (rd_ctx),
		.rd_row  (rd_row),
		.wr_en   (fire1),
		.wr_addr (AW'(port_s1)),
		.wr_ctx  (nxt_ctx),
		.wr_row  (nxt_row)
	);

	// Context update: remap status, restore running status, transpose, store.
	always_comb begin
		chf    = chf_of(cfg.channel_map, port_s1);
		tf     = trf_of(cfg.transpose_map, port_s1);
		b      = byte_s1;
		pos    = rd_ctx.pos;
		len2   = rd_ctx.len2;
		rs     = rd_ctx.run_status;
		nxt_row = rd_row;
		sum    = 9'd0;
		if (pos == 2'd0) begin
			if (!b[7]) begin
				nxt_row[0] = rs;
				pos = 2'd1;
			end else begin
				if (!chf[4]) begin
					b = {b[7:4], chf[3:0]};
				end
				rs   = b;
				len2 = (b[7:4] == ST_PROG) || (b[7:4] == ST_CHPRESS);
			end
		end
		// The note number sits one byte before the end of a three-byte message.
		tr_pos = len2 ? 2'd0 : 2'd1;
		if ((pos == tr_pos) && ((rs[7:4] == ST_NOTE_ON) || (rs[7:4] == ST_NOTE_OFF)) &&
			!b[7]) begin
			sum = {2'b00, b[6:0]} + {{3{tf[5]}}, tf};
			if (sum[8:7] == 2'b00) begin
				b = {1'b0, sum[6:0]};
			end
		end
		nxt_row[pos] = b;
		emit = len2 ? (pos >= 2'd1) : (pos >= 2'd2);
		nxt_ctx.pos        = emit ? 2'd0 : pos + 2'd1;
		nxt_ctx.len2       = len2;
		nxt_ctx.run_status = rs;
	end

	// Stage one retires when its message, if any, fits in the queue.
	assign fire1 = v1_s1 && (!emit || !q_full);
	assign push  = fire1 && emit;
	assign push_msg.bytes = nxt_row;
	assign push_msg.len2  = nxt_ctx.len2;
	assign push_msg.port  = port_s1;

	mmrp_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_msg  (push_msg),
		.full      (q_full),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg_item  (msg_item)
	);

`ifndef SYNTHESIS
	// A stalled stage-one byte keeps its port for the next cycle.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && !src_ready |=> v1_s1 && $stable(port_s1))
		else $error("stage one byte lost while stalled");

	// A dropped byte never enters stage one.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready && drop |=> !v1_s1)
		else $error("dropped byte reached stage one");

	// A message is never pushed into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("message queue overflow");

	// A context write always leaves the position within a message.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire1 |-> (nxt_ctx.pos != 2'd3) && (!nxt_ctx.len2 || nxt_ctx.pos != 2'd2))
		else $error("parse position out of range");
`endif

endmodule

>>> rtl/mmrp_apb_regs.sv
// APB-style configuration registers: channel map and transpose map.
// Depends on mmrp_pkg.
module mmrp_apb_regs import mmrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	typedef enum logic {
		REG_CHANNEL_MAP   = 1'b0,
		REG_TRANSPOSE_MAP = 1'b1
	} reg_idx_t;

	localparam logic [CHMAP_W-1:0] CHMAP_RESET = 25'd470506;

	reg_idx_t           reg_idx;
	logic               wr_stb;
	logic [CHMAP_W-1:0] chmap_q;
	logic [TRMAP_W-1:0] trmap_q;

	// Registers are word aligned; address bit 2 selects the register.
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign wr_stb  = psel && penable && pwrite;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chmap_q <= CHMAP_RESET;
			trmap_q <= '0;
		end else if (wr_stb) begin
			case (reg_idx)
				REG_CHANNEL_MAP:   chmap_q <= pwdata[CHMAP_W-1:0];
				REG_TRANSPOSE_MAP: trmap_q <= pwdata[TRMAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero extended to the bus width.
	always_comb begin
		case (reg_idx)
			REG_CHANNEL_MAP:   prdata = {{(PDATA_W-CHMAP_W){1'b0}}, chmap_q};
			REG_TRANSPOSE_MAP: prdata = {{(PDATA_W-TRMAP_W){1'b0}}, trmap_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.channel_map   = chmap_q;
	assign cfg.transpose_map = trmap_q;

endmodule

>>> rtl/mmrp_state_ram.sv
// Per-port state memories: parse context with reset valid bits, and the
// partial message rows. Registered reads with write-to-read bypass.
// Depends on mmrp_pkg.
module mmrp_state_ram import mmrp_pkg::*; #(
	parameter int NUM_PORTS = NUM_PORTS_DEF,
	localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output ctx_t          rd_ctx,
	output row_t          rd_row,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  ctx_t          wr_ctx,
	input  row_t          wr_row
);

	// Context after reset: start of message, length three, no running status.
	localparam ctx_t CTX_RESET = '{pos: 2'd0, len2: 1'b0, run_status: 8'h00};

	ctx_t ctx_mem [NUM_PORTS];
	row_t row_mem [NUM_PORTS];
	logic [NUM_PORTS-1:0] vld_q;
	logic rvld_q;
	ctx_t ctx_q;
	row_t row_q;
	logic bypass;

	assign bypass = wr_en && (wr_addr == rd_addr);

	// Memory writes.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctx_mem[wr_addr] <= wr_ctx;
			row_mem[wr_addr] <= wr_row;
		end
	end

	// Registered reads; a write to the same entry in the same cycle is passed through.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ctx_q <= bypass ? wr_ctx : ctx_mem[rd_addr];
			row_q <= bypass ? wr_row : row_mem[rd_addr];
		end
	end

	// Valid bits stand in for clearing the context memory at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr] || bypass;
			end
		end
	end

	assign rd_ctx = rvld_q ? ctx_q : CTX_RESET;
	assign rd_row = row_q;

endmodule

>>> rtl/mmrp_out_queue.sv
// Two-entry queue of completed messages and the serializer that sends them
// one byte per transfer. Depends on mmrp_pkg.
module mmrp_out_queue import mmrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  msg_t      push_msg,
	output logic      full,
	output logic      msg_valid,
	input  logic      msg_ready,
	output msg_item_t msg_item
);

	msg_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	msg_t head;
	logic is_last;
	logic pop;
	logic xfer;

	assign head      = ent_q[rd_ptr_q];
	assign full      = (cnt_q == 2'd2);
	assign msg_valid = (cnt_q != 2'd0);
	assign is_last   = (idx_q == (head.len2 ? 2'd1 : 2'd2));
	assign xfer      = msg_valid && msg_ready;
	assign pop       = xfer && is_last;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_msg;
		end
	end

	// Pointers, fill count and byte index of the head message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (xfer) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	assign msg_item.out_byte = head.bytes[idx_q];
	assign msg_item.out_port = head.port;
	assign msg_item.last     = is_last;

endmodule
